// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside reset.
`define ASSERT_PROP(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(name, clk, rstn, ante, cons) \
	`ASSERT_PROP(name, clk, rstn, (ante) |-> (cons))

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
	`ASSERT_PROP(name, clk, rstn, (ante) |=> (cons))

`endif

// ===== sv/bb3_pkg.sv =====
package bb3_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int QDEPTH         = 4;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// Result kinds of one pixel, in emission order.
	localparam int EM_MID_UP  = 0;
	localparam int EM_MID_CUR = 1;
	localparam int EM_END_UP  = 2;
	localparam int EM_END_CUR = 3;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_pix_t;

	typedef struct packed {
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic [11:0] out_row;
		logic [9:0]  out_col;
		logic        frame_done;
	} out_pix_t;

	typedef struct packed {
		logic [2:0][2:0][23:0] win;
		logic [3:0]            emit;
		logic                  top_ok;
		logic                  up_ok;
		logic                  left2;
		logic                  left1;
		logic [11:0]           row_up;
		logic [11:0]           row_cur;
		logic [9:0]            col_mid;
		logic [9:0]            col_end;
	} job_t;

endpackage

// ===== sv/box_blur_3x3_rgb.sv =====
// 3x3 box blur of an RGB frame streamed in raster order, with the neighborhood shrunk to the
// in-image pixels at borders and corners. Each result carries its row and column and frame_done
// marks the last one of the frame; on the final row results leave out of raster order. Writing
// either size register restarts the frame. A pixel is taken unless the front stage is full and
// the four-entry job queue is full; it causes zero to four results. The back end sends one
// result per clock while out_stall is low, so inside the frame the block runs at one pixel per
// clock, and on the final row input waits while each pixel's results (up to two, or up to four
// at the last column) go out. A result passes the front stage, the job queue and two back-end
// registers before it is presented. Two banks of MAX_WIDTH words hold the two previous rows.
module box_blur_3x3_rgb #(
	parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bb3_pkg::in_pix_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output bb3_pkg::out_pix_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [12:0]       cfg_data
);

	bb3_pkg::job_t job, head;
	logic          push, pop, q_full, q_empty;

	bb3_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_full   (q_full),
		.push     (push),
		.job      (job)
	);

	bb3_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(job),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	bb3_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

// ===== sv/bb3_front.sv =====
module bb3_front #(
	parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  bb3_pkg::in_pix_t in_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [12:0]      cfg_data,
	input  logic             q_full,
	output logic             push,
	output bb3_pkg::job_t    job
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [10:0]   width_q;
	logic [12:0]   height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [31:0]   w_eff, h_eff, col32, row32, row_m1, col_m1;
	logic          last_col, last_row, accept, advance;
	logic [23:0]   px;

	logic [23:0]   mem0 [MAX_WIDTH];
	logic [23:0]   mem1 [MAX_WIDTH];

	logic          valid_s1, par_s1;
	logic [23:0]   px_s1, bank0_s1, bank1_s1;
	logic [3:0]    emit_s1;
	logic          top_ok_s1, up_ok_s1, left2_s1, left1_s1;
	logic [11:0]   row_up_s1, row_cur_s1;
	logic [9:0]    col_mid_s1, col_end_s1;

	logic [2:0][2:0][23:0] win_q, win_next;

	assign px = {in_data.in_blue, in_data.in_green, in_data.in_red};

	always_comb begin
		if (width_q == 11'd0) begin
			w_eff = 32'd1;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end else begin
			w_eff = 32'(width_q);
		end
		if (height_q == 13'd0) begin
			h_eff = 32'd1;
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = 32'(MAX_HEIGHT);
		end else begin
			h_eff = 32'(height_q);
		end
	end

	assign col32    = 32'(col_q);
	assign row32    = 32'(row_q);
	assign row_m1   = row32 - 32'd1;
	assign col_m1   = col32 - 32'd1;
	assign last_col = (col32 + 32'd1) >= w_eff;
	assign last_row = (row32 + 32'd1) >= h_eff;

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign advance  = valid_s1 && !q_full;
	assign push     = advance && (emit_s1 != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 13'd480;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bb3_pkg::CFG_WIDTH:  width_q  <= cfg_data[10:0];
					bb3_pkg::CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : RW'(row32 + 32'd1);
				end else begin
					col_q <= CW'(col32 + 32'd1);
				end
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bank0_s1 <= mem0[col_q];
			bank1_s1 <= mem1[col_q];
			if (row_q[0]) begin
				mem1[col_q] <= px;
			end else begin
				mem0[col_q] <= px;
			end
			px_s1      <= px;
			par_s1     <= row_q[0];
			emit_s1[bb3_pkg::EM_MID_UP]  <= (col_q != '0) && (row_q != '0);
			emit_s1[bb3_pkg::EM_MID_CUR] <= (col_q != '0) && last_row;
			emit_s1[bb3_pkg::EM_END_UP]  <= last_col && (row_q != '0);
			emit_s1[bb3_pkg::EM_END_CUR] <= last_col && last_row;
			top_ok_s1  <= row32 >= 32'd2;
			up_ok_s1   <= row_q != '0;
			left2_s1   <= col32 >= 32'd2;
			left1_s1   <= col_q != '0;
			row_up_s1  <= row_m1[11:0];
			row_cur_s1 <= row32[11:0];
			col_mid_s1 <= col_m1[9:0];
			col_end_s1 <= col32[9:0];
		end
	end

	always_comb begin
		win_next       = win_q;
		win_next[0]    = win_q[1];
		win_next[1]    = win_q[2];
		win_next[2][0] = par_s1 ? bank1_s1 : bank0_s1;
		win_next[2][1] = par_s1 ? bank0_s1 : bank1_s1;
		win_next[2][2] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (advance) begin
			win_q <= win_next;
		end
	end

	always_comb begin
		job.win     = win_next;
		job.emit    = emit_s1;
		job.top_ok  = top_ok_s1;
		job.up_ok   = up_ok_s1;
		job.left2   = left2_s1;
		job.left1   = left1_s1;
		job.row_up  = row_up_s1;
		job.row_cur = row_cur_s1;
		job.col_mid = col_mid_s1;
		job.col_end = col_end_s1;
	end

endmodule

// ===== sv/bb3_fifo.sv =====
module bb3_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bb3_pkg::job_t push_data,
	input  logic          pop,
	output bb3_pkg::job_t head,
	output logic          full,
	output logic          empty
);

	localparam int AW = $clog2(bb3_pkg::QDEPTH);

	bb3_pkg::job_t mem_q [bb3_pkg::QDEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0]   count_q;

	assign full  = count_q == (AW+1)'(bb3_pkg::QDEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/bb3_back.sv =====
module bb3_back (
	input  logic              clk,
	input  logic              arst_n,
	input  bb3_pkg::job_t     head,
	input  logic              q_empty,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output bb3_pkg::out_pix_t out_data
);

	// Divisors 6, 12 and 18 are a shift followed by a reciprocal multiply by 1/3 or 1/9,
	// exact for every numerator that a 3x3 window of 8-bit values can produce.
	function automatic logic [7:0] round_mean(input logic [12:0] num, input logic [3:0] n);
		logic [12:0] q;
		logic [25:0] p;
		p = '0;
		case (n)
			4'd1: begin
				q = num >> 1;
			end
			4'd2: begin
				q = num >> 2;
			end
			4'd3: begin
				p = 26'(num[12:1]) * 26'd2731;
				q = p[25:13];
			end
			4'd4: begin
				q = num >> 3;
			end
			4'd6: begin
				p = 26'(num[12:2]) * 26'd2731;
				q = p[25:13];
			end
			default: begin
				p = 26'(num[12:1]) * 26'd3641;
				q = {2'b00, p[25:15]};
			end
		endcase
		return q[7:0];
	endfunction

	logic [3:0]  done_q, pend, selbit;
	logic        is_up, is_mid, last, issue, a_free, out_free;
	logic [2:0]  rmask, cmask;
	logic [1:0]  nr, nc;
	logic [3:0]  n;
	logic [11:0] sr, sg, sb;

	logic        valid_s1;
	logic [11:0] sr_s1, sg_s1, sb_s1;
	logic [3:0]  n_s1;
	logic [11:0] row_s1;
	logic [9:0]  col_s1;
	logic        done_s1;

	logic              out_valid_q;
	bb3_pkg::out_pix_t out_data_q;

	assign pend   = head.emit & ~done_q;
	assign selbit = pend & (~pend + 4'd1);
	assign last   = (pend & ~selbit) == 4'd0;
	assign is_up  = selbit[bb3_pkg::EM_MID_UP] || selbit[bb3_pkg::EM_END_UP];
	assign is_mid = selbit[bb3_pkg::EM_MID_UP] || selbit[bb3_pkg::EM_MID_CUR];

	assign out_free = !out_valid_q || !out_stall;
	assign a_free   = !valid_s1 || out_free;
	assign issue    = !q_empty && a_free;
	assign pop      = issue && last;

	always_comb begin
		if (is_up) begin
			rmask = head.top_ok ? 3'b111 : 3'b110;
		end else begin
			rmask = head.up_ok ? 3'b110 : 3'b100;
		end
		if (is_mid) begin
			cmask = head.left2 ? 3'b111 : 3'b110;
		end else begin
			cmask = head.left1 ? 3'b110 : 3'b100;
		end
		nr = {1'b0, rmask[0]} + {1'b0, rmask[1]} + {1'b0, rmask[2]};
		nc = {1'b0, cmask[0]} + {1'b0, cmask[1]} + {1'b0, cmask[2]};
		n  = {2'b00, nr} * {2'b00, nc};
		sr = '0;
		sg = '0;
		sb = '0;
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if (cmask[c] && rmask[r]) begin
					sr = sr + 12'(head.win[c][r][7:0]);
					sg = sg + 12'(head.win[c][r][15:8]);
					sb = sb + 12'(head.win[c][r][23:16]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				done_q <= last ? 4'd0 : (done_q | selbit);
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sr_s1   <= sr;
			sg_s1   <= sg;
			sb_s1   <= sb;
			n_s1    <= n;
			row_s1  <= is_up ? head.row_up : head.row_cur;
			col_s1  <= is_mid ? head.col_mid : head.col_end;
			done_s1 <= selbit[bb3_pkg::EM_END_CUR];
		end
		if (valid_s1 && out_free) begin
			out_data_q.out_red    <= round_mean({sr_s1, 1'b0} + 13'(n_s1), n_s1);
			out_data_q.out_green  <= round_mean({sg_s1, 1'b0} + 13'(n_s1), n_s1);
			out_data_q.out_blue   <= round_mean({sb_s1, 1'b0} + 13'(n_s1), n_s1);
			out_data_q.out_row    <= row_s1;
			out_data_q.out_col    <= col_s1;
			out_data_q.frame_done <= done_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== sv/bb3_chk.sv =====
`include "assert_macros.svh"

module bb3_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input bb3_pkg::out_pix_t out_data
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`ASSERT_IMPL(a_stall_rise, clk, arst_n, $rose(in_stall), $past(in_valid && !in_stall))
	`ASSERT_NEXT(a_new_frame, clk, arst_n, out_valid && !out_stall && out_data.frame_done, !out_valid || out_data.out_row == 12'd0)

endmodule

bind box_blur_3x3_rgb bb3_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

// ===== tb/sv/box_blur_3x3_rgb_tb.sv =====
`timescale 1ns / 1ps

module box_blur_3x3_rgb_tb;

	localparam int MAXW = bb3_pkg::DEF_MAX_WIDTH;
	localparam int MAXH = bb3_pkg::DEF_MAX_HEIGHT;
	localparam int SETTLE_CYCLES = 20;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PIXELS = 460;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	bb3_pkg::in_pix_t in_data;
	logic out_valid;
	logic out_stall;
	bb3_pkg::out_pix_t out_data;
	logic cfg_we;
	logic cfg_index;
	logic [12:0] cfg_data;

	logic [10:0] blur_width_reg;
	logic [12:0] blur_height_reg;
	logic [23:0] line_mem [2*MAXW];
	logic [23:0] window [3][3];
	int unsigned pos_row;
	int unsigned pos_col;
	bb3_pkg::out_pix_t blurred_q[$];

	int errors;
	int pixels_sent;
	int results_seen;
	int frames_done;
	int idle_cycles;
	bit steady;
	int stall_left;

	box_blur_3x3_rgb u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int unsigned clamp_size(int unsigned v, int unsigned lim);
		if (v == 0)
			return 1;
		return (v > lim) ? lim : v;
	endfunction

	function automatic bb3_pkg::out_pix_t mean_of(int rlo, int clo, int unsigned r,
			int unsigned c, bit done);
		bb3_pkg::out_pix_t o;
		int unsigned sum [3];
		int unsigned n;
		logic [23:0] px;
		sum = '{0, 0, 0};
		n = 0;
		for (int x = clo; x <= 2; x++) begin
			for (int y = rlo; y <= 2; y++) begin
				px = window[x][y];
				for (int ch = 0; ch < 3; ch++)
					sum[ch] += px[8*ch +: 8];
				n++;
			end
		end
		o.out_red = 8'((2*sum[0] + n) / (2*n));
		o.out_green = 8'((2*sum[1] + n) / (2*n));
		o.out_blue = 8'((2*sum[2] + n) / (2*n));
		o.out_row = 12'(r);
		o.out_col = 10'(c);
		o.frame_done = done;
		return o;
	endfunction

	task automatic predict_blur(bb3_pkg::in_pix_t p);
		int unsigned w, h, i, j;
		bit last_row, last_col;
		int rup, rcur, cmid, cend;
		logic [23:0] px;
		w = clamp_size(blur_width_reg, MAXW);
		h = clamp_size(blur_height_reg, MAXH);
		i = pos_row;
		j = pos_col;
		px = {p.in_blue, p.in_green, p.in_red};
		last_row = (i >= h - 1);
		last_col = (j >= w - 1);
		rup = (i >= 2) ? 0 : 1;
		rcur = (i >= 1) ? 1 : 2;
		cmid = (j >= 2) ? 0 : 1;
		cend = (j >= 1) ? 1 : 2;
		for (int x = 0; x < 2; x++)
			for (int y = 0; y < 3; y++)
				window[x][y] = window[x+1][y];
		window[2][0] = line_mem[(i & 1) * MAXW + j % MAXW];
		window[2][1] = line_mem[((i + 1) & 1) * MAXW + j % MAXW];
		window[2][2] = px;
		line_mem[(i & 1) * MAXW + j % MAXW] = px;
		if (j >= 1) begin
			if (i >= 1)
				blurred_q.push_back(mean_of(rup, cmid, i - 1, j - 1, 1'b0));
			if (last_row)
				blurred_q.push_back(mean_of(rcur, cmid, i, j - 1, 1'b0));
		end
		if (last_col) begin
			if (i >= 1)
				blurred_q.push_back(mean_of(rup, cend, i - 1, j, 1'b0));
			if (last_row) begin
				blurred_q.push_back(mean_of(rcur, cend, i, j, 1'b1));
				frames_done++;
			end
		end
		if (last_col) begin
			pos_col = 0;
			pos_row = last_row ? 0 : i + 1;
		end else begin
			pos_col = j + 1;
		end
	endtask

	task automatic report(string msg);
		errors++;
		$display("MISMATCH %s", msg);
	endtask

	task automatic send_pixel(bb3_pkg::in_pix_t p);
		int g;
		g = steady ? 0 : gap_len();
		repeat (g) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data = p;
		do
			@(posedge clk);
		while (in_stall);
		predict_blur(p);
		pixels_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (blurred_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [12:0] val);
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		if (idx == bb3_pkg::CFG_WIDTH)
			blur_width_reg = val[10:0];
		else
			blur_height_reg = val;
		pos_row = 0;
		pos_col = 0;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_size(int unsigned w, int unsigned h);
		write_reg(bb3_pkg::CFG_WIDTH, 13'(w));
		write_reg(bb3_pkg::CFG_HEIGHT, 13'(h));
	endtask

	function automatic bb3_pkg::in_pix_t rand_pixel();
		bb3_pkg::in_pix_t p;
		p = bb3_pkg::in_pix_t'(24'($urandom));
		if ($urandom_range(0, 4) == 0)
			p.in_red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 4) == 0)
			p.in_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 4) == 0)
			p.in_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return p;
	endfunction

	task automatic test_reset_size();
		for (int k = 0; k < 3; k++)
			send_pixel(rand_pixel());
	endtask

	task automatic test_tiny_frames();
		set_size(1, 1);
		send_pixel(bb3_pkg::in_pix_t'{8'hFF, 8'h00, 8'hFF});
		send_pixel(bb3_pkg::in_pix_t'{8'h00, 8'hFF, 8'h00});
		set_size(0, 0);
		send_pixel(bb3_pkg::in_pix_t'{8'h5A, 8'hA5, 8'h01});
		set_size(3, 1);
		for (int k = 0; k < 3; k++)
			send_pixel(rand_pixel());
		set_size(1, 3);
		for (int k = 0; k < 3; k++)
			send_pixel(rand_pixel());
	endtask

	task automatic test_full_scale();
		set_size(3, 3);
		for (int k = 0; k < 9; k++)
			send_pixel((k % 2) ? bb3_pkg::in_pix_t'{8'hFF, 8'hFF, 8'hFF}
				: bb3_pkg::in_pix_t'{8'h00, 8'h00, 8'h00});
	endtask

	task automatic test_oversize_abandon();
		set_size(2047, 8191);
		for (int k = 0; k < 4; k++)
			send_pixel(rand_pixel());
	endtask

	task automatic test_max_width_row();
		set_size(MAXW, 2);
		steady = 1'b1;
		for (int k = 0; k < MAXW / 4; k++)
			send_pixel(rand_pixel());
		steady = 1'b0;
	endtask

	task automatic test_random_frames();
		int unsigned w, h, n, cut;
		bit paused;
		paused = 1'b0;
		while (pixels_sent < RANDOM_PIXELS) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 12);
			h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 9);
			set_size(w, h);
			n = clamp_size(w, MAXW) * clamp_size(h, MAXH);
			cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : n;
			steady = ($urandom_range(0, 4) == 0);
			for (int unsigned k = 0; k < cut; k++) begin
				if (!paused && k == cut / 2 && cut > 4) begin
					drain();
					paused = 1'b1;
				end
				send_pixel(rand_pixel());
			end
			steady = 1'b0;
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			out_stall = 1'b0;
			if (!steady && $urandom_range(0, 3) == 0)
				stall_left = gap_len();
		end
	end

	always @(posedge clk) begin
		bb3_pkg::out_pix_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (blurred_q.size() == 0) begin
				report($sformatf("unexpected result at row %0d col %0d", out_data.out_row,
					out_data.out_col));
			end else begin
				want = blurred_q.pop_front();
				if (out_data.out_red !== want.out_red)
					report($sformatf("out_red: got %0d, expected %0d",
						out_data.out_red, want.out_red));
				if (out_data.out_green !== want.out_green)
					report($sformatf("out_green: got %0d, expected %0d",
						out_data.out_green, want.out_green));
				if (out_data.out_blue !== want.out_blue)
					report($sformatf("out_blue: got %0d, expected %0d",
						out_data.out_blue, want.out_blue));
				if (out_data.out_row !== want.out_row)
					report($sformatf("out_row: got %0d, expected %0d",
						out_data.out_row, want.out_row));
				if (out_data.out_col !== want.out_col)
					report($sformatf("out_col: got %0d, expected %0d",
						out_data.out_col, want.out_col));
				if (out_data.frame_done !== want.frame_done)
					report($sformatf("frame_done: got %0d, expected %0d",
						out_data.frame_done, want.frame_done));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout with %0d results outstanding.", blurred_q.size());
			$display("box_blur_3x3_rgb test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bb3_pkg::CFG_WIDTH;
		cfg_data = '0;
		errors = 0;
		pixels_sent = 0;
		results_seen = 0;
		frames_done = 0;
		idle_cycles = 0;
		steady = 1'b0;
		stall_left = 0;
		blur_width_reg = 11'd640;
		blur_height_reg = 13'd480;
		pos_row = 0;
		pos_col = 0;
		for (int k = 0; k < 2*MAXW; k++)
			line_mem[k] = '0;
		for (int x = 0; x < 3; x++)
			for (int y = 0; y < 3; y++)
				window[x][y] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_size();
		test_tiny_frames();
		test_full_scale();
		test_oversize_abandon();
		test_max_width_row();
		test_random_frames();

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Sent %0d pixels and checked %0d blurred results over %0d completed frames,",
			pixels_sent, results_seen, frames_done);
		$display("covering one-pixel, clamped, maximum-width, abandoned and random-size frames.");
		if (errors == 0 && blurred_q.size() == 0)
			$display("box_blur_3x3_rgb test passed");
		else
			$display("box_blur_3x3_rgb test failed");
		$finish;
	end

endmodule
